### rtl/core/assert_macros.svh
// Assertion helpers. Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define ASSERT_AT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bawf_pkg.sv
package bawf_pkg;

	localparam int VAL_W       = 16;
	localparam int GAP_W       = 8;
	localparam int SCORE_W     = 15;
	localparam int INDEX_W     = 6;
	localparam int CFG_INDEX_W = 2;

	typedef logic signed [VAL_W-1:0] val_t;

	// gap value at the band edge
	localparam val_t EDGE_GAP = '1;

	typedef enum logic {
		OP_PROCESS = 1'b0,
		OP_CLEAR   = 1'b1
	} op_t;

	typedef enum logic {
		DIR_RIGHT = 1'b0,
		DIR_DOWN  = 1'b1
	} dir_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GAP_OPEN   = 2'd0,
		REG_GAP_EXTEND = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		val_t e;
		val_t f;
		val_t h;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic wrap;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		dir_t direction;
		dir_t prev_move;
		logic at_first;
		logic at_last;
	} pe_ctl_t;

	typedef struct packed {
		entry_t lst_prev;
		entry_t lst_here;
		entry_t lst_next;
		val_t   pen_prev;
		val_t   pen_here;
		val_t   pen_next;
	} taps_t;

	typedef struct packed {
		val_t e;
		val_t f;
		val_t h;
		val_t s;
		logic e_ext;
		logic f_ext;
	} cand_t;

	typedef struct packed {
		cand_t              cand;
		logic [INDEX_W-1:0] index;
		logic               last;
	} result_t;

endpackage

### rtl/core/bawf_cell.sv
// One band position: antidiagonal under construction, last and penultimate.
module bawf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  bawf_pkg::cell_ctl_t ctl,
	input  bawf_pkg::entry_t    cur_in,
	input  bawf_pkg::entry_t    lst_in,
	input  bawf_pkg::val_t      pen_in,
	output bawf_pkg::entry_t    cur,
	output bawf_pkg::entry_t    lst,
	output bawf_pkg::val_t      pen
);

	bawf_pkg::entry_t cur_q;
	bawf_pkg::entry_t lst_q;
	bawf_pkg::val_t   pen_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			cur_q <= cur_in;
		end
	end

	// last/pen rotate one place per cell; at the end of an antidiagonal
	// the finished line drops into last and last moves to pen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lst_q <= '0;
			pen_q <= '0;
		end else if (ctl.clear) begin
			lst_q <= '0;
			pen_q <= '0;
		end else if (ctl.shift) begin
			if (ctl.wrap) begin
				lst_q <= cur_in;
				pen_q <= lst_in.h;
			end else begin
				lst_q <= lst_in;
				pen_q <= pen_in;
			end
		end
	end

	assign cur = cur_q;
	assign lst = lst_q;
	assign pen = pen_q;

endmodule

### rtl/core/bawf_pe.sv
// Head-of-band compute: gap candidates, diagonal sum, clamped max.
module bawf_pe (
	input  bawf_pkg::pe_ctl_t                  ctl,
	input  bawf_pkg::taps_t                    taps,
	input  logic signed [bawf_pkg::VAL_W-1:0]  similarity,
	input  logic [bawf_pkg::GAP_W-1:0]         gap_open,
	input  logic [bawf_pkg::GAP_W-1:0]         gap_extend,
	output bawf_pkg::cand_t                    cand
);

	bawf_pkg::val_t   go_v;
	bawf_pkg::val_t   ge_v;
	bawf_pkg::entry_t src_e;
	bawf_pkg::entry_t src_f;
	bawf_pkg::val_t   ext_e, opn_e, ext_f, opn_f;
	logic             none_e, none_f, open_e, open_f;
	bawf_pkg::val_t   e, f, h, ef, efh;
	bawf_pkg::val_t   pen_sel;
	logic             use_pen;
	logic             down, same_move;

	assign go_v = $signed({{(bawf_pkg::VAL_W-bawf_pkg::GAP_W){1'b0}}, gap_open});
	assign ge_v = $signed({{(bawf_pkg::VAL_W-bawf_pkg::GAP_W){1'b0}}, gap_extend});

	assign down      = (ctl.direction == bawf_pkg::DIR_DOWN);
	assign same_move = (ctl.direction == ctl.prev_move);

	// horizontal gap: same position going right, one below going down
	assign src_e  = down ? taps.lst_prev : taps.lst_here;
	assign none_e = down && ctl.at_first;
	assign ext_e  = src_e.e - ge_v;
	assign opn_e  = src_e.h - go_v;
	assign open_e = (opn_e > ext_e);
	assign e      = none_e ? bawf_pkg::EDGE_GAP : (open_e ? opn_e : ext_e);

	// vertical gap: same position going down, one above going right
	assign src_f  = down ? taps.lst_here : taps.lst_next;
	assign none_f = !down && ctl.at_last;
	assign ext_f  = src_f.f - ge_v;
	assign opn_f  = src_f.h - go_v;
	assign open_f = (opn_f > ext_f);
	assign f      = none_f ? bawf_pkg::EDGE_GAP : (open_f ? opn_f : ext_f);

	always_comb begin
		use_pen = 1'b1;
		pen_sel = taps.pen_here;
		if (!same_move) begin
			pen_sel = taps.pen_here;
		end else if (!down && !ctl.at_last) begin
			pen_sel = taps.pen_next;
		end else if (down && !ctl.at_first) begin
			pen_sel = taps.pen_prev;
		end else begin
			use_pen = 1'b0;
		end
	end

	assign h   = use_pen ? similarity + pen_sel : similarity;
	assign ef  = (e > f) ? e : f;
	assign efh = (h > ef) ? h : ef;

	assign cand.e     = e;
	assign cand.f     = f;
	assign cand.h     = h;
	assign cand.s     = efh[bawf_pkg::VAL_W-1] ? '0 : efh;
	assign cand.e_ext = !none_e && !open_e;
	assign cand.f_ext = !none_f && !open_f;

endmodule

### rtl/core/banded_affine_gap_wavefront_core.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// item     | item_valid/item_stall | op, direction, similarity
// result   | result_valid/         | score, from_*, *_extended, cell_index,
//          | result_stall          | last_cell
// cfg      | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One cell per cycle unless stalled: each item is computed at the head of a
// row of BAND storage cells in the cycle of its transfer; its result is
// registered in the output or skid entry. A clear gives no result. Last and
// penultimate storage is flops zeroed by reset at once; no clearing pass.
// A one-entry skid register behind the output keeps item_stall registered;
// items stall only while that entry is occupied.
`include "assert_macros.svh"

module banded_affine_gap_wavefront_core #(
	parameter int BAND = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  op,
	input  logic                                  direction,
	input  logic signed [bawf_pkg::VAL_W-1:0]     similarity,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [bawf_pkg::SCORE_W-1:0]          score,
	output logic                                  from_horizontal,
	output logic                                  from_vertical,
	output logic                                  from_diagonal,
	output logic                                  horizontal_extended,
	output logic                                  vertical_extended,
	output logic [bawf_pkg::INDEX_W-1:0]          cell_index,
	output logic                                  last_cell,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bawf_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [bawf_pkg::GAP_W-1:0]            cfg_data
);

	localparam int CNT_W = $clog2(BAND);

	logic [bawf_pkg::GAP_W-1:0] gap_open_q, gap_extend_q;
	logic [CNT_W-1:0]           cnt_q;
	bawf_pkg::dir_t             prev_move_q;
	logic                       at_first, at_last;
	logic                       xfer, acc_proc, acc_clear;

	bawf_pkg::cell_ctl_t        cell_ctl;
	bawf_pkg::pe_ctl_t          pe_ctl;
	bawf_pkg::taps_t            taps;
	bawf_pkg::cand_t            cand;
	bawf_pkg::entry_t           new_entry;
	bawf_pkg::result_t          new_res;

	bawf_pkg::entry_t           cur_w [BAND-1:1];
	bawf_pkg::entry_t           lst_w [BAND];
	bawf_pkg::val_t             pen_w [BAND];

	bawf_pkg::result_t          s1_q, skid_q;
	logic                       s1_valid_q, skid_valid_q;
	logic                       load_s1;
	logic                       nz;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_open_q   <= '0;
			gap_extend_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bawf_pkg::REG_GAP_OPEN:   gap_open_q   <= cfg_data;
				bawf_pkg::REG_GAP_EXTEND: gap_extend_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item transfer and band position
	assign item_stall = skid_valid_q;
	assign xfer       = item_valid && !item_stall;
	assign acc_clear  = xfer && (op == bawf_pkg::OP_CLEAR);
	assign acc_proc   = xfer && (op == bawf_pkg::OP_PROCESS);
	assign at_first   = (cnt_q == '0);
	assign at_last    = (cnt_q == CNT_W'(BAND - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			prev_move_q <= bawf_pkg::DIR_RIGHT;
		end else if (acc_clear) begin
			cnt_q       <= '0;
			prev_move_q <= bawf_pkg::DIR_RIGHT;
		end else if (acc_proc) begin
			if (at_last) begin
				cnt_q       <= '0;
				prev_move_q <= bawf_pkg::dir_t'(direction);
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// head compute
	assign pe_ctl.direction = bawf_pkg::dir_t'(direction);
	assign pe_ctl.prev_move = prev_move_q;
	assign pe_ctl.at_first  = at_first;
	assign pe_ctl.at_last   = at_last;

	assign taps.lst_prev = lst_w[BAND-1];
	assign taps.lst_here = lst_w[0];
	assign taps.lst_next = lst_w[1];
	assign taps.pen_prev = pen_w[BAND-1];
	assign taps.pen_here = pen_w[0];
	assign taps.pen_next = pen_w[1];

	bawf_pe u_pe (
		.ctl        (pe_ctl),
		.taps       (taps),
		.similarity (similarity),
		.gap_open   (gap_open_q),
		.gap_extend (gap_extend_q),
		.cand       (cand)
	);

	assign new_entry.e = cand.e;
	assign new_entry.f = cand.f;
	assign new_entry.h = cand.s;

	assign new_res.cand  = cand;
	assign new_res.index = bawf_pkg::INDEX_W'(cnt_q);
	assign new_res.last  = at_last;

	// band of storage cells; cell 0 always holds the current position
	assign cell_ctl.shift = acc_proc;
	assign cell_ctl.wrap  = at_last;
	assign cell_ctl.clear = acc_clear;

	for (genvar k = 0; k < BAND; k++) begin : g_cell
		bawf_pkg::entry_t cur_in_k;
		bawf_pkg::entry_t cur_out_k;

		if (k == BAND - 1) begin : g_tail
			assign cur_in_k = new_entry;
		end else begin : g_body
			assign cur_in_k = cur_w[k+1];
		end

		if (k > 0) begin : g_cur
			assign cur_w[k] = cur_out_k;
		end

		bawf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.cur_in (cur_in_k),
			.lst_in (lst_w[(k + 1) % BAND]),
			.pen_in (pen_w[(k + 1) % BAND]),
			.cur    (cur_out_k),
			.lst    (lst_w[k]),
			.pen    (pen_w[k])
		);
	end

	// output register with skid entry
	assign load_s1 = !s1_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_s1) begin
			s1_valid_q   <= skid_valid_q || acc_proc;
			skid_valid_q <= 1'b0;
		end else if (acc_proc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			s1_q <= skid_valid_q ? skid_q : new_res;
		end else if (acc_proc) begin
			skid_q <= new_res;
		end
	end

	// zero score carries no traceback
	assign nz = (s1_q.cand.s != '0);

	assign result_valid        = s1_valid_q;
	assign score               = s1_q.cand.s[bawf_pkg::SCORE_W-1:0];
	assign from_horizontal     = nz && (s1_q.cand.s == s1_q.cand.e);
	assign from_vertical       = nz && (s1_q.cand.s == s1_q.cand.f);
	assign from_diagonal       = nz && (s1_q.cand.s == s1_q.cand.h);
	assign horizontal_extended = nz && s1_q.cand.e_ext;
	assign vertical_extended   = nz && s1_q.cand.f_ext;
	assign cell_index          = s1_q.index;
	assign last_cell           = s1_q.last;

	`ASSERT_AT(a_skid_behind_out, !skid_valid_q || s1_valid_q, "skid entry without output entry")
	`ASSERT_NEXT(a_band_wrap, acc_proc && at_last, cnt_q == '0, "band position did not wrap")
	`ASSERT_NEXT(a_clear_restart, acc_clear, cnt_q == '0 && prev_move_q == bawf_pkg::DIR_RIGHT, "clear did not restart wavefront")
	`ASSERT_NEXT(a_result_order, result_valid && result_stall && skid_valid_q, result_valid && skid_valid_q, "held result lost")

endmodule

### dv/banded_affine_gap_wavefront_core_tb.sv
module banded_affine_gap_wavefront_core_tb;
	import bawf_pkg::*;

	localparam int BAND        = 48;
	localparam int SLOTS       = 3;
	localparam int IDLE_PCT    = 18;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 6;
	localparam int LIMIT       = 200000;
	localparam int SHOW_MAX    = 10;

	// indexes past the register list; writes there must not land anywhere
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct {
		op_t  op;
		dir_t dir;
		val_t sim;
	} cell_req_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               fh;
		logic               fv;
		logic               fd;
		logic               hx;
		logic               vx;
		logic [INDEX_W-1:0] idx;
		logic               last;
	} cell_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic op = OP_PROCESS;
	logic direction = DIR_RIGHT;
	logic signed [VAL_W-1:0] similarity = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [SCORE_W-1:0] score;
	logic from_horizontal, from_vertical, from_diagonal;
	logic horizontal_extended, vertical_extended;
	logic [INDEX_W-1:0] cell_index;
	logic last_cell;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [GAP_W-1:0] cfg_data = '0;

	banded_affine_gap_wavefront_core #(
		.BAND(BAND)
	) i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.op                 (op),
		.direction          (direction),
		.similarity         (similarity),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.score              (score),
		.from_horizontal    (from_horizontal),
		.from_vertical      (from_vertical),
		.from_diagonal      (from_diagonal),
		.horizontal_extended(horizontal_extended),
		.vertical_extended  (vertical_extended),
		.cell_index         (cell_index),
		.last_cell          (last_cell),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// wavefront mirror
	val_t gap_h_mem [SLOTS*BAND];
	val_t gap_v_mem [SLOTS*BAND];
	val_t score_mem [SLOTS*BAND];
	int unsigned slot_ptr, cell_cnt;
	dir_t prev_dir;
	logic [GAP_W-1:0] gap_open_q = '0;
	logic [GAP_W-1:0] gap_extend_q = '0;

	cell_req_t pending_cells [$];
	cell_out_t expected_cells [$];

	bit idle_on = 1'b1;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;
	int mismatches = 0;
	int cells_checked = 0;
	int clears_seen = 0;
	int reg_writes = 0;
	int edge_hits = 0;
	int offband_hits = 0;
	int zero_hits = 0;
	int cycle_count = 0;

	function automatic void wipe_wavefront();
		foreach (score_mem[k]) begin
			gap_h_mem[k] = '0;
			gap_v_mem[k] = '0;
			score_mem[k] = '0;
		end
		slot_ptr = 0;
		cell_cnt = 0;
		prev_dir = DIR_RIGHT;
	endfunction

	// better of extending the gap or opening one; a tie counts as extension
	function automatic val_t gap_pick(val_t gap_prev, val_t h_prev, output logic ext);
		val_t by_ext, by_open;
		by_ext = gap_prev - val_t'({8'd0, gap_extend_q});
		by_open = h_prev - val_t'({8'd0, gap_open_q});
		if (by_open > by_ext) begin
			ext = 1'b0;
			return by_open;
		end
		ext = 1'b1;
		return by_ext;
	endfunction

	function automatic void score_cell(logic op_bit, logic dir_bit, val_t sim);
		int unsigned i, cur, lst, pen;
		dir_t d;
		val_t e, f, h, s;
		logic hx, vx;
		cell_out_t r;
		if (op_bit == OP_CLEAR) begin
			wipe_wavefront();
			clears_seen++;
			return;
		end
		hx = 1'b0;
		vx = 1'b0;
		d = dir_t'(dir_bit);
		i = (cell_cnt >= BAND) ? 0 : cell_cnt;
		cur = slot_ptr % SLOTS;
		lst = (cur + SLOTS - 1) % SLOTS;
		pen = (cur + SLOTS - 2) % SLOTS;

		if (d == DIR_RIGHT)
			e = gap_pick(gap_h_mem[lst*BAND+i], score_mem[lst*BAND+i], hx);
		else if (i == 0) begin
			e = EDGE_GAP;
			edge_hits++;
		end else
			e = gap_pick(gap_h_mem[lst*BAND+i-1], score_mem[lst*BAND+i-1], hx);

		if (d == DIR_DOWN)
			f = gap_pick(gap_v_mem[lst*BAND+i], score_mem[lst*BAND+i], vx);
		else if (i + 1 >= BAND) begin
			f = EDGE_GAP;
			edge_hits++;
		end else
			f = gap_pick(gap_v_mem[lst*BAND+i+1], score_mem[lst*BAND+i+1], vx);

		h = sim;
		if (d != prev_dir)
			h = sim + score_mem[pen*BAND+i];
		else if (d == DIR_RIGHT && i + 1 < BAND)
			h = sim + score_mem[pen*BAND+i+1];
		else if (d == DIR_DOWN && i > 0)
			h = sim + score_mem[pen*BAND+i-1];
		else
			offband_hits++;

		s = (e > f) ? e : f;
		if (h > s)
			s = h;
		if (s < 0)
			s = '0;
		r.fh = (s == e);
		r.fv = (s == f);
		r.fd = (s == h);
		r.hx = hx;
		r.vx = vx;
		if (s == 0) begin
			r.fh = 1'b0;
			r.fv = 1'b0;
			r.fd = 1'b0;
			r.hx = 1'b0;
			r.vx = 1'b0;
			zero_hits++;
		end

		gap_h_mem[cur*BAND+i] = e;
		gap_v_mem[cur*BAND+i] = f;
		score_mem[cur*BAND+i] = s;

		r.score = s[SCORE_W-1:0];
		r.idx = INDEX_W'(i);
		r.last = (i + 1 >= BAND);
		expected_cells.push_back(r);

		if (r.last) begin
			cell_cnt = 0;
			slot_ptr = (cur + 1) % SLOTS;
			prev_dir = d;
		end else
			cell_cnt = i + 1;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		cell_req_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			op <= OP_PROCESS;
			direction <= DIR_RIGHT;
			similarity <= '0;
		end else begin
			if (item_valid && !item_stall)
				score_cell(op, direction, similarity);
			if (!item_valid || !item_stall) begin
				if (pending_cells.size() != 0 &&
				    !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
					nxt = pending_cells.pop_front();
					item_valid <= 1'b1;
					op <= nxt.op;
					direction <= nxt.dir;
					similarity <= nxt.sim;
				end else
					item_valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		cell_out_t want, got;
		if (!arst_n)
			result_stall <= 1'b0;
		else begin
			if (result_valid && !result_stall) begin
				got.score = score;
				got.fh = from_horizontal;
				got.fv = from_vertical;
				got.fd = from_diagonal;
				got.hx = horizontal_extended;
				got.vx = vertical_extended;
				got.idx = cell_index;
				got.last = last_cell;
				if (expected_cells.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("unexpected result transfer: score %0d cell %0d",
						         got.score, got.idx);
				end else begin
					want = expected_cells.pop_front();
					cells_checked++;
					if (got.score !== want.score || got.fh !== want.fh ||
					    got.fv !== want.fv || got.fd !== want.fd ||
					    got.hx !== want.hx || got.vx !== want.vx ||
					    got.idx !== want.idx || got.last !== want.last) begin
						mismatches++;
						if (mismatches <= SHOW_MAX) begin
							$display("mismatch %0d exp: %0d hvd %b%b%b ext %b%b last %b",
							         want.idx, want.score, want.fh, want.fv, want.fd,
							         want.hx, want.vx, want.last);
							$display("  got: %0d hvd %b%b%b ext %b%b idx %0d last %b",
							         got.score, got.fh, got.fv, got.fd, got.hx,
							         got.vx, got.idx, got.last);
						end
					end
				end
			end
			if (hold_done != hold_asked) begin
				hold_done = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else
				result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("banded_affine_gap_wavefront_core test failed");
		$finish;
	end

	task automatic push_cell(op_t o, dir_t d, val_t sim);
		cell_req_t c;
		c.op = o;
		c.dir = d;
		c.sim = sim;
		pending_cells.push_back(c);
	endtask

	function automatic val_t rand_sim();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return val_t'(int'($urandom_range(16)) - 6);
		if (roll < 90)
			return val_t'(int'($urandom_range(400)) - 200);
		return val_t'($urandom);
	endfunction

	// one antidiagonal, with the odd stray clear or per-cell direction flip
	task automatic queue_diagonal(dir_t d);
		dir_t cd;
		for (int c = 0; c < BAND; c++) begin
			if ($urandom_range(199) == 0)
				push_cell(OP_CLEAR, dir_t'($urandom_range(1)), val_t'($urandom));
			cd = ($urandom_range(99) < 3) ? dir_t'(~d) : d;
			push_cell(OP_PROCESS, cd, rand_sim());
		end
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [GAP_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_GAP_OPEN:   gap_open_q = data;
			REG_GAP_EXTEND: gap_extend_q = data;
			default:        ;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_cells.size() != 0 || item_valid || expected_cells.size() != 0);
		// a trailing clear gives no result but may still be in flight
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		logic [GAP_W-1:0] open_set [6];
		logic [GAP_W-1:0] ext_set [6];
		wipe_wavefront();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_GAP_OPEN, 8'd12);
		write_reg(REG_GAP_EXTEND, 8'd3);
		write_reg(REG_SPARE_HI, 8'hFF);

		// directed: field extremes, direction changes, clears mid-diagonal
		push_cell(OP_CLEAR, DIR_DOWN, 16'sh7FFF);
		push_cell(OP_PROCESS, DIR_RIGHT, 16'sh7FFF);
		push_cell(OP_PROCESS, DIR_RIGHT, -16'sh8000);
		push_cell(OP_PROCESS, DIR_RIGHT, 16'sh0000);
		push_cell(OP_PROCESS, DIR_RIGHT, 16'sh0001);
		push_cell(OP_PROCESS, DIR_RIGHT, -16'sh0001);
		push_cell(OP_PROCESS, DIR_DOWN, 16'sh5555);
		push_cell(OP_PROCESS, DIR_DOWN, -16'sh5556);
		push_cell(OP_PROCESS, DIR_RIGHT, 16'sd100);
		push_cell(OP_CLEAR, DIR_RIGHT, 16'sh0000);
		push_cell(OP_PROCESS, DIR_DOWN, 16'sh7FFF);
		push_cell(OP_PROCESS, DIR_DOWN, 16'sd50);
		push_cell(OP_PROCESS, DIR_DOWN, -16'sd50);
		push_cell(OP_PROCESS, DIR_RIGHT, 16'sh7FFF);
		push_cell(OP_PROCESS, DIR_RIGHT, 16'sh7FFF);
		push_cell(OP_CLEAR, DIR_DOWN, -16'sh8000);
		push_cell(OP_PROCESS, DIR_DOWN, 16'sd0);
		push_cell(OP_PROCESS, DIR_RIGHT, 16'sd3);
		wait_drained();

		open_set = '{8'd255, 8'd12, 8'd255, 8'd0, 8'd0, 8'd0};
		ext_set = '{8'd255, 8'd2, 8'd0, 8'd255, 8'd0, 8'd0};
		open_set[4] = GAP_W'($urandom);
		ext_set[4] = GAP_W'($urandom);

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_GAP_OPEN, open_set[p]);
			write_reg(REG_GAP_EXTEND, ext_set[p]);
			if (p == 4)
				write_reg(REG_SPARE_LO, GAP_W'($urandom));
			if ($urandom_range(1))
				push_cell(OP_CLEAR, dir_t'($urandom_range(1)), val_t'($urandom));
			repeat (6) queue_diagonal(dir_t'($urandom_range(1)));
			// phase 3 runs flat out; phase 1 backs up the block behind a long stall
			idle_on = (p != 3 && p != 1);
			if (p == 1)
				hold_asked++;
			wait_drained();
			idle_on = 1'b1;
		end

		$display("checked %0d cells over %0d clears and %0d register writes",
		         cells_checked, clears_seen, reg_writes);
		$display("band-edge gaps %0d, off-band diagonals %0d, zero scores %0d",
		         edge_hits, offband_hits, zero_hits);
		if (mismatches == 0 && expected_cells.size() == 0)
			$display("banded_affine_gap_wavefront_core test passed");
		else
			$display("banded_affine_gap_wavefront_core test failed");
		$finish;
	end

endmodule
